// ----- rtl/core/imk_pkg.sv -----
package imk_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int OFS_W  = 32;

  localparam logic [1:0] MODE_STRAIGHT  = 2'd0;
  localparam logic [1:0] MODE_BUG       = 2'd1;
  localparam logic [1:0] MODE_IAMBIC    = 2'd2;
  localparam logic [1:0] MODE_ULTIMATIC = 2'd3;

  localparam logic [1:0] SP_NONE = 2'd0;
  localparam logic [1:0] SP_ELEM = 2'd1;
  localparam logic [1:0] SP_CHAR = 2'd2;
  localparam logic [1:0] SP_WORD = 2'd3;

  localparam logic [1:0] EL_NONE = 2'd0;
  localparam logic [1:0] EL_DIT  = 2'd1;
  localparam logic [1:0] EL_DAH  = 2'd3;

  localparam logic [7:0] CODE_EMPTY   = 8'h80;
  localparam logic [7:0] CODE_INVALID = 8'hFF;
  localparam logic [7:0] CODE_ONE     = 8'h01;
  localparam logic [7:0] RES_NONE     = 8'h00;
  localparam logic [7:0] RES_KEY_DOWN = 8'h01;

  localparam logic [9:0] TICKS_PER_MS = 10'd1000;

  // floor(y / 25) = (y * DIV25_MAGIC) >> DIV25_SHIFT for any 30-bit y
  localparam logic [30:0] DIV25_MAGIC = 31'd1374389535;
  localparam int          DIV25_SHIFT = 35;

  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

  typedef enum logic [2:0] {
    REG_KEYER_MODE   = 3'd0,
    REG_PADDLE_SWAP  = 3'd1,
    REG_SPACING_MODE = 3'd2,
    REG_MEMORY_MASK  = 3'd3,
    REG_DIT_TICKS    = 3'd4,
    REG_WEIGHT_PCT   = 3'd5,
    REG_LAG_MS       = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KS_SPACE = 3'd1,
    KS_GAP   = 3'd2,
    KS_IDLE  = 3'd3,
    KS_DOWN  = 3'd4,
    KS_HOLD  = 3'd5,
    KS_UP    = 3'd6
  } ks_e;

  typedef struct packed {
    logic [31:0] timestamp;
    logic        key_pin_a;
    logic        key_pin_b;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  result_code;
    logic        tx_start;
    logic [31:0] tx_until;
  } out_rsp_t;

  typedef struct packed {
    logic [1:0]  keyer_mode;
    logic        paddle_swap;
    logic [1:0]  spacing_mode;
    logic [1:0]  memory_mask;
    logic [23:0] dit_ticks;
    logic [6:0]  weight_pct;
    logic [7:0]  lag_ms;
  } cfg_t;

  // signed tick offsets from poll time to mark end and space end
  typedef struct packed {
    logic signed [OFS_W-1:0] mark_dit;
    logic signed [OFS_W-1:0] space_dit;
    logic signed [OFS_W-1:0] mark_dah;
    logic signed [OFS_W-1:0] space_dah;
  } ofs_t;

endpackage

// ----- rtl/core/iambic_morse_keyer_unit.sv -----
// channel   dir  payload      handshake
// in        in   in_req_t     in_valid_i / in_stall_o
// out       out  out_rsp_t    out_valid_o / out_stall_i
// cfg       in   APB regs     psel / penable / pwrite / pready
//
// One poll accepted per cycle while not stalled; each result passes through the request and result registers.
// Keyer state is updated as a request fires from the request register into the result register.
// After reset and after every register write, requests are stalled
// while the weight/lag tick offsets are recomputed (4-stage multiply pipeline).
// A stalled result holds the request register; an empty one still takes requests.
module iambic_morse_keyer_unit #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  imk_pkg::in_req_t            in_req_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  output imk_pkg::out_rsp_t           out_rsp_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [imk_pkg::ADDR_W-1:0]  paddr,
  input  logic [imk_pkg::DATA_W-1:0]  pwdata,
  output logic [imk_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import imk_pkg::*;

  cfg_t     cfg;
  ofs_t     ofs;
  logic     busy, adv, accept, fire;
  in_req_t  req_q;
  logic     req_valid_q;
  out_rsp_t rsp, rsp_q;
  logic     rsp_valid_q;

  assign pready = 1'b1;

  imk_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg),
    .busy_o  (busy)
  );

  imk_timing u_timing (
    .clk_i (clk_i),
    .cfg_i (cfg),
    .ofs_o (ofs)
  );

  assign adv        = !rsp_valid_q || !out_stall_i;
  assign in_stall_o = busy || (req_valid_q && !adv);
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = req_valid_q && adv;

  imk_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .ofs_i  (ofs),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        req_valid_q <= 1'b1;
      end else if (fire) begin
        req_valid_q <= 1'b0;
      end
      if (adv) begin
        rsp_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_req_i;
    if (fire)   rsp_q <= rsp;
  end

  assign out_rsp_o   = rsp_q;
  assign out_valid_o = rsp_valid_q;

endmodule

// ----- rtl/core/imk_cfg.sv -----
module imk_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [imk_pkg::ADDR_W-1:0]  paddr,
  input  logic [imk_pkg::DATA_W-1:0]  pwdata,
  output logic [imk_pkg::DATA_W-1:0]  prdata,
  output imk_pkg::cfg_t               cfg_o,
  output logic                        busy_o
);
  import imk_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] settle_q, settle_d;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[ADDR_W-1:2];
  assign wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_KEYER_MODE:   cfg_d.keyer_mode   = pwdata[1:0];
        REG_PADDLE_SWAP:  cfg_d.paddle_swap  = pwdata[0];
        REG_SPACING_MODE: cfg_d.spacing_mode = pwdata[1:0];
        REG_MEMORY_MASK:  cfg_d.memory_mask  = pwdata[1:0];
        REG_DIT_TICKS:    cfg_d.dit_ticks    = pwdata[23:0];
        REG_WEIGHT_PCT:   cfg_d.weight_pct   = pwdata[6:0];
        REG_LAG_MS:       cfg_d.lag_ms       = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_KEYER_MODE:   prdata = DATA_W'(cfg_q.keyer_mode);
      REG_PADDLE_SWAP:  prdata = DATA_W'(cfg_q.paddle_swap);
      REG_SPACING_MODE: prdata = DATA_W'(cfg_q.spacing_mode);
      REG_MEMORY_MASK:  prdata = DATA_W'(cfg_q.memory_mask);
      REG_DIT_TICKS:    prdata = DATA_W'(cfg_q.dit_ticks);
      REG_WEIGHT_PCT:   prdata = DATA_W'(cfg_q.weight_pct);
      REG_LAG_MS:       prdata = DATA_W'(cfg_q.lag_ms);
      default:          prdata = '0;
    endcase
  end

  // busy is held after a register write until the timing offsets follow it
  always_comb begin
    settle_d = settle_q;
    if (wr) begin
      settle_d = SETTLE_CYCLES;
    end else if (settle_q != 3'd0) begin
      settle_d = settle_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keyer_mode   <= MODE_IAMBIC;
      cfg_q.paddle_swap  <= 1'b0;
      cfg_q.spacing_mode <= SP_ELEM;
      cfg_q.memory_mask  <= 2'd3;
      cfg_q.dit_ticks    <= 24'd66666;
      cfg_q.weight_pct   <= 7'd50;
      cfg_q.lag_ms       <= 8'd0;
      settle_q           <= SETTLE_CYCLES;
    end else begin
      cfg_q    <= cfg_d;
      settle_q <= settle_d;
    end
  end

  assign cfg_o  = cfg_q;
  assign busy_o = (settle_q != 3'd0);

endmodule

// ----- rtl/core/imk_timing.sv -----
module imk_timing (
  input  logic          clk_i,
  input  imk_pkg::cfg_t cfg_i,
  output imk_pkg::ofs_t ofs_o
);
  import imk_pkg::*;

  logic signed [9:0]  c1, c2;
  logic               neg1_a, neg2_a;
  logic [7:0]         mag1, mag2;
  logic [31:0]        prod1_d, prod2_d;
  logic [17:0]        lagk_d;

  logic [31:0]        prod1_q, prod2_q;
  logic               neg1_q, neg2_q;
  logic [17:0]        lagk_q;

  logic [60:0]        r1, r2;
  logic [25:0]        q1_q, q2_q;
  logic               neg1_b_q, neg2_b_q;

  logic signed [OFS_W-1:0] w1_d, w2_d, w1_q, w2_q;
  logic signed [OFS_W-1:0] dt1, dt3, lagk;
  ofs_t                    ofs_d, ofs_q;

  // stage A: |dit * (2w - 100)| and |dit * (200 - 2w)|
  always_comb begin
    c1      = $signed({2'b00, cfg_i.weight_pct, 1'b0}) - 10'sd100;
    c2      = 10'sd200 - $signed({2'b00, cfg_i.weight_pct, 1'b0});
    neg1_a  = c1[9];
    neg2_a  = c2[9];
    mag1    = neg1_a ? 8'(-c1) : c1[7:0];
    mag2    = neg2_a ? 8'(-c2) : c2[7:0];
    prod1_d = 32'(cfg_i.dit_ticks) * 32'(mag1);
    prod2_d = 32'(cfg_i.dit_ticks) * 32'(mag2);
    lagk_d  = 18'(cfg_i.lag_ms) * 18'(TICKS_PER_MS);
  end

  // stage B: divide by 100 as shift by 2 then reciprocal of 25
  assign r1 = 61'(prod1_q[31:2]) * 61'(DIV25_MAGIC);
  assign r2 = 61'(prod2_q[31:2]) * 61'(DIV25_MAGIC);

  // stage C: restore sign, truncation toward zero
  assign w1_d = neg1_b_q ? -$signed(OFS_W'(q1_q)) : $signed(OFS_W'(q1_q));
  assign w2_d = neg2_b_q ? -$signed(OFS_W'(q2_q)) : $signed(OFS_W'(q2_q));

  // stage D: offsets per element
  always_comb begin
    dt1             = $signed(OFS_W'(cfg_i.dit_ticks));
    dt3             = dt1 + (dt1 <<< 1);
    lagk            = $signed(OFS_W'(lagk_q));
    ofs_d.mark_dit  = dt1 + w1_q + lagk;
    ofs_d.space_dit = dt1 + w1_q + w2_q;
    ofs_d.mark_dah  = dt3 + w1_q + lagk;
    ofs_d.space_dah = dt3 + w1_q + w2_q;
  end

  always_ff @(posedge clk_i) begin
    prod1_q  <= prod1_d;
    prod2_q  <= prod2_d;
    neg1_q   <= neg1_a;
    neg2_q   <= neg2_a;
    lagk_q   <= lagk_d;
    q1_q     <= r1[60:DIV25_SHIFT];
    q2_q     <= r2[60:DIV25_SHIFT];
    neg1_b_q <= neg1_q;
    neg2_b_q <= neg2_q;
    w1_q     <= w1_d;
    w2_q     <= w2_d;
    ofs_q    <= ofs_d;
  end

  assign ofs_o = ofs_q;

endmodule

// ----- rtl/core/imk_core.sv -----
module imk_core #(
  parameter int TIME_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  imk_pkg::in_req_t req_i,
  input  imk_pkg::cfg_t    cfg_i,
  input  imk_pkg::ofs_t    ofs_i,
  output imk_pkg::out_rsp_t rsp_o
);
  import imk_pkg::*;

  ks_e                   ks_q, ks_d;
  logic [2:0]            gc_q, gc_d;
  logic                  sq_q, sq_d;
  logic [1:0]            le_q, le_d;
  logic [1:0]            se_q, se_d;
  logic [7:0]            cc_q, cc_d;
  logic [TIME_WIDTH-1:0] rd_q, rd_d;
  logic [TIME_WIDTH-1:0] sd_q, sd_d;

  logic [TIME_WIDTH-1:0] now, d_sd, d_rd, txu, mk, sp, dtw;
  logic                  dit, dah, p_sd, p_rd, rd_hit, txs, is_key;
  logic [7:0]            ret;
  logic signed [OFS_W-1:0] ofs_mk, ofs_sp;

  always_comb begin
    ks_d   = ks_q;
    gc_d   = gc_q;
    sq_d   = sq_q;
    le_d   = le_q;
    se_d   = se_q;
    cc_d   = cc_q;
    rd_d   = rd_q;
    sd_d   = sd_q;
    ret    = RES_NONE;
    txs    = 1'b0;
    txu    = '0;
    now    = TIME_WIDTH'(req_i.timestamp);
    dtw    = TIME_WIDTH'(cfg_i.dit_ticks);
    is_key = (cfg_i.keyer_mode == MODE_STRAIGHT) || (cfg_i.keyer_mode == MODE_BUG);

    if (cfg_i.keyer_mode == MODE_STRAIGHT) begin
      dah = ~req_i.key_pin_a;
      dit = 1'b0;
    end else if (!cfg_i.paddle_swap) begin
      dit = ~req_i.key_pin_a;
      dah = ~req_i.key_pin_b;
    end else begin
      dit = ~req_i.key_pin_b;
      dah = ~req_i.key_pin_a;
    end

    // deadline passed when (deadline - now) is negative
    d_sd   = sd_q - now;
    d_rd   = rd_q - now;
    p_sd   = d_sd[TIME_WIDTH-1];
    p_rd   = d_rd[TIME_WIDTH-1];
    rd_hit = (cfg_i.spacing_mode == SP_NONE) &&
             ((dit && le_q == EL_DIT) || (dah && le_q == EL_DAH));

    unique case (ks_q)
      KS_SPACE: begin
        if (rd_hit) rd_d = now;
        if (p_rd && !rd_hit) ks_d = KS_GAP;
      end
      KS_GAP, KS_IDLE: begin
        if (ks_q == KS_GAP && p_sd) ks_d = KS_IDLE;
        if ((ks_q == KS_IDLE || gc_q >= 3'd4) && p_sd) begin
          if (gc_q == 3'd1) begin
            ret  = cc_q;
            cc_d = CODE_EMPTY;
            if (cfg_i.spacing_mode == SP_CHAR || cfg_i.spacing_mode == SP_WORD) begin
              ks_d = KS_GAP;
            end
          end else if (gc_q >= 3'd4 && gc_q <= 3'd6) begin
            if (gc_q == 3'd4) ret = cc_q;
            if (cfg_i.spacing_mode == SP_WORD) ks_d = KS_GAP;
          end
          if (gc_q != 3'd7) gc_d = gc_q + 3'd1;
          if (cfg_i.keyer_mode == MODE_BUG) ks_d = KS_IDLE;
          sd_d = sd_q + dtw;
        end
      end
      KS_DOWN: begin
        if (p_sd) ks_d = KS_HOLD;
      end
      KS_UP: begin
        if (p_rd) begin
          ks_d = KS_IDLE;
          se_d = EL_NONE;
          sd_d = now + dtw;
          gc_d = 3'd0;
          if (cc_q[0]) cc_d = CODE_INVALID;
          else         cc_d = {1'b1, cc_q[7:1]};
        end
      end
      default: ;
    endcase

    if (is_key) begin
      if (dah) begin
        if (ks_d < KS_DOWN) begin
          ks_d = KS_DOWN;
          sd_d = now;
        end
        if (ks_d < KS_UP) begin
          rd_d = now;
          txs  = 1'b1;
          txu  = now;
          ret  = RES_KEY_DOWN;
        end
        le_d = EL_DAH;
        se_d = EL_NONE;
      end else if (ks_d == KS_HOLD) begin
        if (se_d == EL_DIT) begin
          ks_d = KS_IDLE;
        end else begin
          ks_d = KS_UP;
          txs  = 1'b1;
          txu  = now;
          ret  = RES_KEY_DOWN;
        end
      end
    end else if (ks_d > KS_IDLE) begin
      ks_d = KS_UP;
    end

    // paddle sampling and memory
    if (se_d == EL_NONE) begin
      if (ks_d > KS_SPACE) begin
        if (dit && dah) begin
          if (sq_d && cfg_i.keyer_mode == MODE_ULTIMATIC) se_d = le_d;
          else if (le_d == EL_DIT)                        se_d = EL_DAH;
          else                                            se_d = EL_DIT;
          sq_d = 1'b1;
        end else begin
          if (dit) se_d = EL_DIT;
          if (dah) se_d = EL_DAH;
          sq_d = 1'b0;
        end
      end else if (!sq_d || cfg_i.keyer_mode != MODE_ULTIMATIC) begin
        if (dit && (le_d == EL_DAH || gc_d != 3'd0) && cfg_i.memory_mask[0]) begin
          se_d = EL_DIT;
          sq_d = 1'b1;
        end
        if (dah && (le_d == EL_DIT || gc_d != 3'd0) && cfg_i.memory_mask[1]) begin
          se_d = EL_DAH;
          sq_d = 1'b1;
        end
      end
    end

    ofs_mk = (se_d == EL_DAH) ? ofs_i.mark_dah  : ofs_i.mark_dit;
    ofs_sp = (se_d == EL_DAH) ? ofs_i.space_dah : ofs_i.space_dit;
    mk     = now + TIME_WIDTH'(ofs_mk);
    sp     = now + TIME_WIDTH'(ofs_sp);

    if (ks_d == KS_IDLE && se_d != EL_NONE) begin
      txs = 1'b1;
      txu = mk;
      ret = RES_KEY_DOWN;
      if (cfg_i.spacing_mode != SP_NONE) begin
        rd_d = sp;
        sd_d = sp;
      end else begin
        rd_d = mk;
        sd_d = mk;
      end
      gc_d = 3'd0;
      if (cc_d[0]) begin
        if (cc_d != CODE_ONE || se_d == EL_DAH) cc_d = CODE_INVALID;
      end else begin
        cc_d = {(se_d == EL_DAH), cc_d[7:1]};
      end
      le_d = se_d;
      se_d = EL_NONE;
      ks_d = KS_SPACE;
    end

    rsp_o.result_code = (cfg_i.keyer_mode == MODE_STRAIGHT) ? RES_NONE : ret;
    rsp_o.tx_start    = txs;
    rsp_o.tx_until    = txs ? 32'(txu) : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q <= KS_IDLE;
      gc_q <= 3'd2;
      sq_q <= 1'b0;
      le_q <= EL_NONE;
      se_q <= EL_NONE;
      cc_q <= CODE_EMPTY;
      rd_q <= '0;
      sd_q <= '0;
    end else if (fire_i) begin
      ks_q <= ks_d;
      gc_q <= gc_d;
      sq_q <= sq_d;
      le_q <= le_d;
      se_q <= se_d;
      cc_q <= cc_d;
      rd_q <= rd_d;
      sd_q <= sd_d;
    end
  end

endmodule
